@@ rtl/wvp_pkg.sv @@
// Shared types, constants and saturation helpers for the wheel velocity controller.
`default_nettype none

package wvp_pkg;

    localparam int AddrW = 5;

    localparam logic [15:0] WrapLimit = 16'd30000;

    localparam logic [31:0] ResetSpeedScale = 32'd0;
    localparam logic [31:0] ResetDistScale  = 32'd0;
    localparam logic [30:0] ResetUpStep     = 31'd328;
    localparam logic [30:0] ResetDownStep   = 31'd328;
    localparam logic signed [31:0] ResetGainFf = 32'sd983040;
    localparam logic signed [31:0] ResetGainP  = 32'sd131072;
    localparam logic signed [31:0] ResetGainI  = 32'sd6554;
    localparam logic signed [31:0] ResetGainD  = 32'sd0;

    localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SatMin = 32'sh8000_0000;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_TARGET = 2'd1,
        KIND_START  = 2'd2,
        KIND_IGNORE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_SPEED_SCALE = 3'd0,
        REG_DIST_SCALE  = 3'd1,
        REG_UP_STEP     = 3'd2,
        REG_DOWN_STEP   = 3'd3,
        REG_GAIN_FF     = 3'd4,
        REG_GAIN_P      = 3'd5,
        REG_GAIN_I      = 3'd6,
        REG_GAIN_D      = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SPD,
        MUL_GAP,
        MUL_DST,
        MUL_FF,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MSPD,
        ST_MGAP,
        ST_MDST,
        ST_MFF,
        ST_MP,
        ST_MI,
        ST_MD,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [31:0]        speed_scale;
        logic [31:0]        distance_scale;
        logic [30:0]        up_step;
        logic [30:0]        down_step;
        logic signed [31:0] gain_ff;
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
    } cfg_t;

    typedef struct packed {
        logic    load;
        logic    prep;
        logic    err_upd;
        logic    commit;
        mul_op_t mul_op;
    } dp_cmd_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? SatMin : SatMax;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
        if ((&v[49:31]) || !(|v[49:31])) begin
            return v[31:0];
        end
        return v[49] ? SatMin : SatMax;
    endfunction

endpackage

`default_nettype wire

@@ rtl/wvp_regs.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none

module wvp_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [wvp_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output wvp_pkg::cfg_t                  cfg
);
    import wvp_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_scale    <= ResetSpeedScale;
            cfg_reg.distance_scale <= ResetDistScale;
            cfg_reg.up_step        <= ResetUpStep;
            cfg_reg.down_step      <= ResetDownStep;
            cfg_reg.gain_ff        <= ResetGainFf;
            cfg_reg.gain_p         <= ResetGainP;
            cfg_reg.gain_i         <= ResetGainI;
            cfg_reg.gain_d         <= ResetGainD;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (idx)
                REG_SPEED_SCALE: cfg_reg.speed_scale    <= pwdata;
                REG_DIST_SCALE:  cfg_reg.distance_scale <= pwdata;
                REG_UP_STEP:     cfg_reg.up_step        <= pwdata[30:0];
                REG_DOWN_STEP:   cfg_reg.down_step      <= pwdata[30:0];
                REG_GAIN_FF:     cfg_reg.gain_ff        <= pwdata;
                REG_GAIN_P:      cfg_reg.gain_p         <= pwdata;
                REG_GAIN_I:      cfg_reg.gain_i         <= pwdata;
                REG_GAIN_D:      cfg_reg.gain_d         <= pwdata;
                default:         cfg_reg.gain_d         <= cfg_reg.gain_d;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SPEED_SCALE: prdata = cfg_reg.speed_scale;
            REG_DIST_SCALE:  prdata = cfg_reg.distance_scale;
            REG_UP_STEP:     prdata = {1'b0, cfg_reg.up_step};
            REG_DOWN_STEP:   prdata = {1'b0, cfg_reg.down_step};
            REG_GAIN_FF:     prdata = cfg_reg.gain_ff;
            REG_GAIN_P:      prdata = cfg_reg.gain_p;
            REG_GAIN_I:      prdata = cfg_reg.gain_i;
            REG_GAIN_D:      prdata = cfg_reg.gain_d;
            default:         prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/wvp_ctrl.sv @@
// Sequencer that steps one request through the shared-multiplier datapath.
`default_nettype none

module wvp_ctrl (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] kind,
    input  wire logic       out_ready,
    output logic            in_ready,
    output logic            out_valid,
    output wvp_pkg::dp_cmd_t cmd
);
    import wvp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (kind_t'(kind) == KIND_TICK) ? ST_PREP : ST_FIN;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_MSPD;
            end
            ST_MSPD:
            begin
                cmd.mul_op = MUL_SPD;
                state_next = ST_MGAP;
            end
            ST_MGAP:
            begin
                cmd.mul_op = MUL_GAP;
                state_next = ST_MDST;
            end
            ST_MDST:
            begin
                cmd.mul_op  = MUL_DST;
                cmd.err_upd = 1'b1;
                state_next  = ST_MFF;
            end
            ST_MFF:
            begin
                cmd.mul_op = MUL_FF;
                state_next = ST_MP;
            end
            ST_MP:
            begin
                cmd.mul_op = MUL_P;
                state_next = ST_MI;
            end
            ST_MI:
            begin
                cmd.mul_op = MUL_I;
                state_next = ST_MD;
            end
            ST_MD:
            begin
                cmd.mul_op = MUL_D;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/wvp_dp.sv @@
// Datapath: encoder deltas, ramp, shared multiplier, PID accumulation and held outputs.
`default_nettype none

module wvp_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wvp_pkg::dp_cmd_t   cmd,
    input  wire wvp_pkg::cfg_t      cfg,
    input  wire logic [1:0]         kind,
    input  wire logic [15:0]        left_count,
    input  wire logic [15:0]        right_count,
    input  wire logic signed [31:0] new_target,
    output logic signed [31:0]      duty,
    output logic signed [31:0]      ramped_target,
    output logic signed [31:0]      speed,
    output logic signed [31:0]      travelled,
    output logic signed [31:0]      speed_error,
    output logic signed [31:0]      wheel_speed_gap
);
    import wvp_pkg::*;

    // latched request
    logic [1:0]         kind_reg;
    logic [15:0]        lc_reg;
    logic [15:0]        rc_reg;
    logic signed [31:0] tgt_reg;

    // controller state
    logic [15:0]        prev_left_reg;
    logic [15:0]        prev_right_reg;
    logic signed [31:0] ltot_reg;
    logic signed [31:0] rtot_reg;
    logic signed [31:0] goal_reg;
    logic signed [31:0] ramp_reg;
    logic               up_reg;
    logic signed [31:0] integ_reg;
    logic signed [31:0] last_err_reg;

    // held results
    logic signed [31:0] duty_reg;
    logic signed [31:0] ramped_target_reg;
    logic signed [31:0] speed_reg;
    logic signed [31:0] travelled_reg;
    logic signed [31:0] speed_error_reg;
    logic signed [31:0] wheel_speed_gap_reg;

    // working values
    logic signed [32:0] csum_reg;
    logic signed [32:0] cgap_reg;
    logic signed [32:0] ctot_reg;
    logic signed [31:0] speed_val_reg;
    logic signed [31:0] gap_val_reg;
    logic signed [31:0] dist_val_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] derr_reg;
    logic signed [65:0] prod_reg;
    mul_op_t            prod_op_reg;
    logic               scl_neg_reg;
    logic               scl_hi_reg;
    logic signed [49:0] acc_reg;

    // encoder deltas and totals
    logic [15:0]        dl16;
    logic [15:0]        dr16;
    logic signed [16:0] dl;
    logic signed [16:0] dr;
    logic signed [32:0] dl_ext;
    logic signed [32:0] dr_ext;
    logic signed [32:0] ltot_ext;
    logic signed [32:0] rtot_ext;
    logic signed [31:0] ltot_next;
    logic signed [31:0] rtot_next;
    logic signed [32:0] ltot_next_ext;
    logic signed [32:0] rtot_next_ext;

    // ramp
    logic signed [32:0] ramp_ext;
    logic signed [32:0] up_ext;
    logic signed [32:0] down_ext;
    logic signed [31:0] ramp_sat;
    logic signed [31:0] ramp_next;

    // error
    logic signed [32:0] speed_val_ext;
    logic signed [31:0] err_val;
    logic signed [32:0] err_val_ext;
    logic signed [32:0] integ_ext;
    logic signed [32:0] last_err_ext;
    logic signed [31:0] integ_next;
    logic signed [31:0] derr_val;

    // multiplier
    logic signed [32:0] cnt_sel;
    logic [32:0]        cnt_mag;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_next;

    // finish
    logic signed [65:0] prod_rnd;
    logic signed [49:0] q_val;
    logic [31:0]        sc_scale;
    logic [65:0]        sc_full;
    logic [65:0]        sc_p;
    logic signed [31:0] sc_res;

    assign dl16 = lc_reg - prev_left_reg;
    assign dr16 = rc_reg - prev_right_reg;
    assign dl   = (dl16 > WrapLimit) ? {1'b1, dl16} : {1'b0, dl16};
    assign dr   = (dr16 > WrapLimit) ? {1'b1, dr16} : {1'b0, dr16};

    assign dl_ext        = {{16{dl[16]}}, dl};
    assign dr_ext        = {{16{dr[16]}}, dr};
    assign ltot_ext      = {ltot_reg[31], ltot_reg};
    assign rtot_ext      = {rtot_reg[31], rtot_reg};
    assign ltot_next     = sat33(ltot_ext + dl_ext);
    assign rtot_next     = sat33(rtot_ext + dr_ext);
    assign ltot_next_ext = {ltot_next[31], ltot_next};
    assign rtot_next_ext = {rtot_next[31], rtot_next};

    assign ramp_ext = {ramp_reg[31], ramp_reg};
    assign up_ext   = {2'b00, cfg.up_step};
    assign down_ext = {2'b00, cfg.down_step};
    assign ramp_sat = sat33(up_reg ? (ramp_ext + up_ext) : (ramp_ext - down_ext));

    always_comb
    begin
        if (up_reg)
        begin
            ramp_next = (ramp_sat >= goal_reg) ? goal_reg : ramp_sat;
        end
        else
        begin
            ramp_next = (ramp_sat <= goal_reg) ? goal_reg : ramp_sat;
        end
    end

    assign speed_val_ext = {speed_val_reg[31], speed_val_reg};
    assign err_val       = sat33(ramp_ext - speed_val_ext);
    assign err_val_ext   = {err_val[31], err_val};
    assign integ_ext     = {integ_reg[31], integ_reg};
    assign last_err_ext  = {last_err_reg[31], last_err_reg};
    assign integ_next    = sat33(integ_ext + err_val_ext);
    assign derr_val      = sat33(err_val_ext - last_err_ext);

    always_comb
    begin
        case (cmd.mul_op)
            MUL_SPD: cnt_sel = csum_reg;
            MUL_GAP: cnt_sel = cgap_reg;
            default: cnt_sel = ctot_reg;
        endcase
    end

    assign cnt_mag = cnt_sel[32] ? 33'(-cnt_sel) : 33'(cnt_sel);

    always_comb
    begin
        case (cmd.mul_op)
            MUL_SPD, MUL_GAP:
            begin
                mul_a = {1'b0, cnt_mag[31:0]};
                mul_b = {1'b0, cfg.speed_scale};
            end
            MUL_DST:
            begin
                mul_a = {1'b0, cnt_mag[31:0]};
                mul_b = {1'b0, cfg.distance_scale};
            end
            MUL_FF:
            begin
                mul_a = {cfg.gain_ff[31], cfg.gain_ff};
                mul_b = {err_reg[31], err_reg};
            end
            MUL_P:
            begin
                mul_a = {cfg.gain_p[31], cfg.gain_p};
                mul_b = {err_reg[31], err_reg};
            end
            MUL_I:
            begin
                mul_a = {cfg.gain_i[31], cfg.gain_i};
                mul_b = {integ_reg[31], integ_reg};
            end
            MUL_D:
            begin
                mul_a = {cfg.gain_d[31], cfg.gain_d};
                mul_b = {derr_reg[31], derr_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 66'(mul_a) * 66'(mul_b);

    assign prod_rnd = prod_reg + 66'sd32768;
    assign q_val    = prod_rnd[65:16];

    assign sc_scale = (prod_op_reg == MUL_DST) ? cfg.distance_scale : cfg.speed_scale;
    assign sc_full  = $unsigned(prod_reg)
                    + (scl_hi_reg ? {2'b00, sc_scale, 32'd0} : 66'd0)
                    + ((prod_op_reg == MUL_GAP) ? 66'd2048 : 66'd4096);
    assign sc_p     = (prod_op_reg == MUL_GAP) ? (sc_full >> 12) : (sc_full >> 13);

    always_comb
    begin
        if (scl_neg_reg)
        begin
            sc_res = (sc_p > 66'h8000_0000) ? SatMin : 32'(-sc_p[31:0]);
        end
        else
        begin
            sc_res = (sc_p > 66'h7FFF_FFFF) ? SatMax : sc_p[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            lc_reg   <= left_count;
            rc_reg   <= right_count;
            tgt_reg  <= new_target;
        end
        if (cmd.prep)
        begin
            csum_reg <= dl_ext + dr_ext;
            cgap_reg <= dr_ext - dl_ext;
            ctot_reg <= ltot_next_ext + rtot_next_ext;
        end
        if (cmd.err_upd)
        begin
            err_reg  <= err_val;
            derr_reg <= derr_val;
        end
        prod_reg    <= prod_next;
        scl_neg_reg <= cnt_sel[32];
        scl_hi_reg  <= cnt_mag[32];
        case (prod_op_reg)
            MUL_SPD: speed_val_reg <= sc_res;
            MUL_GAP: gap_val_reg   <= sc_res;
            MUL_DST: dist_val_reg  <= sc_res;
            MUL_FF:  acc_reg       <= q_val;
            MUL_P, MUL_I, MUL_D:
                     acc_reg       <= acc_reg + q_val;
            default: acc_reg       <= acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_op_reg         <= MUL_NONE;
            prev_left_reg       <= '0;
            prev_right_reg      <= '0;
            ltot_reg            <= '0;
            rtot_reg            <= '0;
            goal_reg            <= '0;
            ramp_reg            <= '0;
            up_reg              <= 1'b0;
            integ_reg           <= '0;
            last_err_reg        <= '0;
            duty_reg            <= '0;
            ramped_target_reg   <= '0;
            speed_reg           <= '0;
            travelled_reg       <= '0;
            speed_error_reg     <= '0;
            wheel_speed_gap_reg <= '0;
        end
        else
        begin
            prod_op_reg <= cmd.mul_op;
            if (cmd.prep)
            begin
                prev_left_reg  <= lc_reg;
                prev_right_reg <= rc_reg;
                ltot_reg       <= ltot_next;
                rtot_reg       <= rtot_next;
                ramp_reg       <= ramp_next;
            end
            if (cmd.err_upd)
            begin
                integ_reg    <= integ_next;
                last_err_reg <= err_val;
            end
            if (cmd.commit)
            begin
                case (kind_t'(kind_reg))
                    KIND_TICK:
                    begin
                        duty_reg            <= sat50(acc_reg);
                        ramped_target_reg   <= ramp_reg;
                        speed_reg           <= speed_val_reg;
                        travelled_reg       <= dist_val_reg;
                        speed_error_reg     <= err_reg;
                        wheel_speed_gap_reg <= gap_val_reg;
                    end
                    KIND_TARGET:
                    begin
                        goal_reg <= tgt_reg;
                        up_reg   <= (tgt_reg > ramp_reg);
                    end
                    KIND_START:
                    begin
                        integ_reg <= '0;
                        duty_reg  <= '0;
                    end
                    default:
                    begin
                        goal_reg <= goal_reg;
                    end
                endcase
            end
        end
    end

    assign duty            = duty_reg;
    assign ramped_target   = ramped_target_reg;
    assign speed           = speed_reg;
    assign travelled       = travelled_reg;
    assign speed_error     = speed_error_reg;
    assign wheel_speed_gap = wheel_speed_gap_reg;

endmodule

`default_nettype wire

@@ rtl/wheel_velocity_pid_with_ramp.sv @@
// Top level: wheel velocity feedforward plus PID controller with a ramped target.
//
// Input channel (in_valid/in_ready) carries one request: a control tick with two
// free-running encoder counts, a new target speed, or a start command that
// clears the integrator. Each request produces exactly one result on the output
// channel (out_valid/out_ready): duty, ramped target, speed, distance, speed
// error and wheel-speed gap, all signed Q16.16.
// A control tick steps through prepare, the multiply states, accumulate and
// finish; the cost is the single shared 33x33 multiplier, used seven times in
// sequence (three count scalings, four PID terms). Set-target, start and
// unused codes go straight from acceptance to the finish state. One request is
// in flight at a time; in_ready is high only while the sequencer is idle, so a
// new request is taken only after the previous result has been committed.
// The result sits in an output register; while it waits for out_ready the next
// request may be accepted and processed, and its result waits until the held
// one is taken.
// Reset clears all controller state and the held outputs to zero and loads the
// register defaults. Configuration is written through the APB-style port,
// register i at byte address 4*i, and should be written only while idle.
`default_nettype none

module wheel_velocity_pid_with_ramp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [wvp_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                kind,
    input  wire logic [15:0]               left_count,
    input  wire logic [15:0]               right_count,
    input  wire logic signed [31:0]        new_target,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [31:0]             duty,
    output logic signed [31:0]             ramped_target,
    output logic signed [31:0]             speed,
    output logic signed [31:0]             travelled,
    output logic signed [31:0]             speed_error,
    output logic signed [31:0]             wheel_speed_gap
);
    import wvp_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;

    wvp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wvp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    wvp_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg             (cfg),
        .kind            (kind),
        .left_count      (left_count),
        .right_count     (right_count),
        .new_target      (new_target),
        .duty            (duty),
        .ramped_target   (ramped_target),
        .speed           (speed),
        .travelled       (travelled),
        .speed_error     (speed_error),
        .wheel_speed_gap (wheel_speed_gap)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a request without going busy");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a request in flight");

    a_busy_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("went busy without an accepted request");

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid || out_ready))
        else $error("result committed over an untaken one");

endmodule

`default_nettype wire

@@ tb/wheel_velocity_pid_with_ramp_tb.sv @@
// Self-checking testbench for the wheel velocity PID controller with ramped target.
`timescale 1ns / 1ps

import wvp_pkg::*;

typedef struct {
    logic signed [31:0] duty;
    logic signed [31:0] ramp;
    logic signed [31:0] spd;
    logic signed [31:0] trav;
    logic signed [31:0] err;
    logic signed [31:0] gap;
} drive_report_t;

class drive_scoreboard;
    bit [31:0]     speed_scale;
    bit [31:0]     distance_scale;
    bit [30:0]     up_step;
    bit [30:0]     down_step;
    int            gain_ff;
    int            gain_p;
    int            gain_i;
    int            gain_d;
    bit [15:0]     prev_left;
    bit [15:0]     prev_right;
    int            left_total;
    int            right_total;
    int            goal;
    int            ramp;
    bit            ramping_up;
    int            err_sum;
    int            last_err;
    drive_report_t held;
    drive_report_t reports_due[$];
    int            bad_fields;

    function new();
        speed_scale = 0;
        distance_scale = 0;
        up_step = 328;
        down_step = 328;
        gain_ff = 983040;
        gain_p = 131072;
        gain_i = 6554;
        gain_d = 0;
        prev_left = 0;
        prev_right = 0;
        left_total = 0;
        right_total = 0;
        goal = 0;
        ramp = 0;
        ramping_up = 1'b0;
        err_sum = 0;
        last_err = 0;
        held = '{0, 0, 0, 0, 0, 0};
        bad_fields = 0;
    endfunction

    function void set_reg(reg_idx_t idx, bit [31:0] v);
        case (idx)
            REG_SPEED_SCALE: speed_scale = v;
            REG_DIST_SCALE:  distance_scale = v;
            REG_UP_STEP:     up_step = v[30:0];
            REG_DOWN_STEP:   down_step = v[30:0];
            REG_GAIN_FF:     gain_ff = v;
            REG_GAIN_P:      gain_p = v;
            REG_GAIN_I:      gain_i = v;
            default:         gain_d = v;
        endcase
    endfunction

    function int clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    function int wrap_step(bit [15:0] now, bit [15:0] prev);
        bit [15:0] d;
        int        r;
        d = now - prev;
        r = {16'd0, d};
        if (r > 30000)
            r -= 65536;
        return r;
    endfunction

    // round half away from zero on the magnitude, then saturate
    function int scale_counts(longint c, bit [31:0] s, int sh);
        bit        neg;
        bit [63:0] m;
        bit [63:0] p;
        neg = c < 0;
        m = neg ? 64'(-c) : 64'(c);
        p = (m * {32'd0, s} + (64'd1 << (sh - 1))) >> sh;
        if (neg)
            return (p > 64'h8000_0000) ? 32'sh8000_0000 : int'(-longint'(p));
        return (p > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(p);
    endfunction

    function longint q16_product(int a, int b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return p >>> 16;
    endfunction

    function void advance_controller(kind_t k, bit [15:0] lc, bit [15:0] rc, int tgt);
        int     dl;
        int     dr;
        int     spd;
        int     gap;
        int     trav;
        int     err;
        int     derr;
        longint r;
        case (k)
            KIND_TICK:
            begin
                dl = wrap_step(lc, prev_left);
                dr = wrap_step(rc, prev_right);
                prev_left = lc;
                prev_right = rc;
                left_total = clamp32(longint'(left_total) + dl);
                right_total = clamp32(longint'(right_total) + dr);
                spd = scale_counts(longint'(dl) + dr, speed_scale, 13);
                gap = scale_counts(longint'(dr) - dl, speed_scale, 12);
                trav = scale_counts(longint'(left_total) + right_total, distance_scale, 13);
                r = ramping_up ? longint'(ramp) + longint'(up_step)
                               : longint'(ramp) - longint'(down_step);
                ramp = clamp32(r);
                if (ramping_up ? ramp >= goal : ramp <= goal)
                    ramp = goal;
                err = clamp32(longint'(ramp) - spd);
                err_sum = clamp32(longint'(err_sum) + err);
                derr = clamp32(longint'(err) - last_err);
                last_err = err;
                r = q16_product(gain_ff, err) + q16_product(gain_p, err)
                  + q16_product(gain_i, err_sum) + q16_product(gain_d, derr);
                held.duty = clamp32(r);
                held.ramp = ramp;
                held.spd = spd;
                held.trav = trav;
                held.err = err;
                held.gap = gap;
            end
            KIND_TARGET:
            begin
                goal = tgt;
                ramping_up = goal > ramp;
            end
            KIND_START:
            begin
                err_sum = 0;
                held.duty = 0;
            end
            default: ;
        endcase
        reports_due.push_back(held);
    endfunction

    function void note_mismatch(string what);
        bad_fields++;
        if (bad_fields <= 10)
            $display("mismatch: %s", what);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    function void check_report(logic signed [31:0] duty, logic signed [31:0] ramp_now,
                               logic signed [31:0] spd, logic signed [31:0] trav,
                               logic signed [31:0] err, logic signed [31:0] gap);
        drive_report_t want;
        if (reports_due.size() == 0)
        begin
            note_mismatch($sformatf("result with duty %0d and no request pending", duty));
            return;
        end
        want = reports_due.pop_front();
        compare_field("duty", want.duty, duty);
        compare_field("ramped_target", want.ramp, ramp_now);
        compare_field("speed", want.spd, spd);
        compare_field("travelled", want.trav, trav);
        compare_field("speed_error", want.err, err);
        compare_field("wheel_speed_gap", want.gap, gap);
    endfunction

    function int failures();
        return bad_fields + reports_due.size();
    endfunction
endclass

module wheel_velocity_pid_with_ramp_tb;
    import wvp_pkg::*;

    localparam int unsigned CycleLimit = 1000000;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [AddrW-1:0]          paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                kind;
    logic [15:0]               left_count;
    logic [15:0]               right_count;
    logic signed [31:0]        new_target;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [31:0]        duty;
    logic signed [31:0]        ramped_target;
    logic signed [31:0]        speed;
    logic signed [31:0]        travelled;
    logic signed [31:0]        speed_error;
    logic signed [31:0]        wheel_speed_gap;

    drive_scoreboard sb = new();
    int unsigned     cycle_count = 0;
    int              hold_off_cycles = 0;
    bit [15:0]       count_left_now = 0;
    bit [15:0]       count_right_now = 0;

    wheel_velocity_pid_with_ramp DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .left_count(left_count),
        .right_count(right_count),
        .new_target(new_target),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .duty(duty),
        .ramped_target(ramped_target),
        .speed(speed),
        .travelled(travelled),
        .speed_error(speed_error),
        .wheel_speed_gap(wheel_speed_gap)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("wheel_velocity_pid_with_ramp_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_report(duty, ramped_target, speed, travelled, speed_error,
                            wheel_speed_gap);
    end

    initial
    begin : result_sink
        int mode;
        int span;
        out_ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            for (int k = 0; k < span; k++)
            begin
                @(negedge clk);
                if (hold_off_cycles > 0)
                begin
                    out_ready = 1'b0;
                    hold_off_cycles--;
                end
                else
                begin
                    case (mode)
                        0:       out_ready = 1'b1;
                        1:       out_ready = 1'($urandom_range(0, 1));
                        2:       out_ready = (k % 4 == 3);
                        default: out_ready = ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, bit [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_request(kind_t k, bit [15:0] lc, bit [15:0] rc, bit [31:0] tgt);
        in_valid = 1'b1;
        kind = k;
        left_count = lc;
        right_count = rc;
        new_target = tgt;
        do
            @(posedge clk);
        while (!in_ready);
        sb.advance_controller(k, lc, rc, tgt);
        if (k == KIND_TICK)
        begin
            count_left_now = lc;
            count_right_now = rc;
        end
        @(negedge clk);
    endtask

    task automatic pause_sender(int n);
        if (n > 0)
        begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic wait_all_reported();
        in_valid = 1'b0;
        while (sb.reports_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic bit [31:0] pick_reg_value(reg_idx_t idx);
        int sel;
        sel = $urandom_range(0, 9);
        case (idx)
            REG_UP_STEP, REG_DOWN_STEP:
                return sel == 0 ? 32'd0 : sel == 1 ? 32'h7FFF_FFFF :
                       sel == 2 ? ($urandom & 32'h7FFF_FFFF) : $urandom_range(1, 1 << 18);
            REG_SPEED_SCALE, REG_DIST_SCALE:
                return sel == 0 ? 32'd0 : sel == 1 ? 32'hFFFF_FFFF :
                       sel == 2 ? $urandom : $urandom_range(1, 1 << 25);
            default:
                return sel == 0 ? 32'h8000_0000 : sel == 1 ? 32'h7FFF_FFFF :
                       sel == 2 ? $urandom : sel == 3 ? 32'd0 :
                       $urandom_range(0, 1 << 21) - (1 << 20);
        endcase
    endfunction

    function automatic bit [31:0] pick_target();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 10 << 16) - (2 << 16);
        endcase
    endfunction

    task automatic run_stream(int count);
        int        sent;
        int        burst;
        int        sel;
        bit [15:0] lc;
        bit [15:0] rc;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < count; b++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 80)
                begin
                    case ($urandom_range(0, 19))
                        0:
                        begin
                            lc = 16'($urandom);
                            rc = 16'($urandom);
                        end
                        1:
                        begin
                            lc = count_left_now + 16'd30000 + 16'($urandom_range(0, 1));
                            rc = count_right_now - 16'd30000 - 16'($urandom_range(0, 1));
                        end
                        default:
                        begin
                            lc = count_left_now + 16'($urandom_range(0, 360) - 60);
                            rc = count_right_now + 16'($urandom_range(0, 360) - 60);
                        end
                    endcase
                    send_request(KIND_TICK, lc, rc, $urandom);
                    sent++;
                end
                else if (sel < 88)
                begin
                    send_request(KIND_TARGET, 16'($urandom), 16'($urandom), pick_target());
                    sent++;
                end
                else if (sel < 95)
                begin
                    send_request(KIND_START, 16'($urandom), 16'($urandom), $urandom);
                    sent++;
                end
                else
                    send_request(KIND_IGNORE, 16'($urandom), 16'($urandom), $urandom);
            end
            pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15));
        end
        in_valid = 1'b0;
    endtask

    initial
    begin : stimulus
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        kind = KIND_TICK;
        left_count = '0;
        right_count = '0;
        new_target = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: zero scales, default ramp and gains
        send_request(KIND_TICK, 16'd0, 16'd0, $urandom);
        send_request(KIND_TARGET, 16'($urandom), 16'($urandom), 32'h0010_0000);
        send_request(KIND_TICK, 16'd100, 16'd100, $urandom);
        send_request(KIND_START, 16'($urandom), 16'($urandom), $urandom);
        send_request(KIND_TICK, 16'd30101, 16'd30100, $urandom);
        send_request(KIND_TICK, 16'hFFFF, 16'h0000, $urandom);
        send_request(KIND_IGNORE, 16'($urandom), 16'($urandom), $urandom);
        send_request(KIND_TARGET, 16'($urandom), 16'($urandom), 32'h8000_0000);
        send_request(KIND_TICK, 16'hFFFF, 16'hFFFF, $urandom);
        send_request(KIND_TICK, 16'h0000, 16'h0000, $urandom);

        // full-scale settings
        wait_all_reported();
        write_reg(REG_SPEED_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_DIST_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_UP_STEP, 32'h7FFF_FFFF);
        write_reg(REG_DOWN_STEP, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_FF, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_P, 32'h8000_0000);
        write_reg(REG_GAIN_I, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_D, 32'h8000_0000);
        send_request(KIND_TARGET, 16'($urandom), 16'($urandom), 32'h7FFF_FFFF);
        send_request(KIND_TICK, count_left_now + 16'd30000, count_right_now - 16'd30000,
                     $urandom);
        send_request(KIND_TICK, count_left_now + 16'd29999, count_right_now + 16'd30000,
                     $urandom);
        send_request(KIND_TARGET, 16'($urandom), 16'($urandom), 32'h8000_0000);
        send_request(KIND_TICK, count_left_now - 16'd30000, count_right_now - 16'd30000,
                     $urandom);
        send_request(KIND_START, 16'($urandom), 16'($urandom), $urandom);
        send_request(KIND_TICK, count_left_now, count_right_now, $urandom);

        // zero steps, opposite gain extremes
        wait_all_reported();
        write_reg(REG_SPEED_SCALE, 32'd1);
        write_reg(REG_DIST_SCALE, 32'd1);
        write_reg(REG_UP_STEP, 32'd0);
        write_reg(REG_DOWN_STEP, 32'd0);
        write_reg(REG_GAIN_FF, 32'h8000_0000);
        write_reg(REG_GAIN_P, 32'h7FFF_FFFF);
        write_reg(REG_GAIN_I, 32'h8000_0000);
        write_reg(REG_GAIN_D, 32'h7FFF_FFFF);
        send_request(KIND_TARGET, 16'($urandom), 16'($urandom), 32'h0001_0000);
        send_request(KIND_TICK, count_left_now + 16'd5, count_right_now + 16'd7, $urandom);
        send_request(KIND_TICK, count_left_now + 16'd5, count_right_now + 16'd3, $urandom);
        send_request(KIND_TARGET, 16'($urandom), 16'($urandom), 32'hFFFF_0000);
        send_request(KIND_TICK, count_left_now - 16'd2, count_right_now - 16'd9, $urandom);

        for (int phase = 0; phase < 12; phase++)
        begin
            wait_all_reported();
            for (int i = 0; i < 8; i++)
                write_reg(reg_idx_t'(i), pick_reg_value(reg_idx_t'(i)));
            if (phase == 2 || phase == 7)
                hold_off_cycles = $urandom_range(300, 600);
            run_stream(170);
        end

        wait_all_reported();
        repeat (30) @(posedge clk);
        if (sb.failures() == 0)
            $display("wheel_velocity_pid_with_ramp_tb passed");
        else
            $display("wheel_velocity_pid_with_ramp_tb failed");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/wvp_pkg.sv
rtl/wvp_regs.sv
rtl/wvp_ctrl.sv
rtl/wvp_dp.sv
rtl/wheel_velocity_pid_with_ramp.sv
tb/wheel_velocity_pid_with_ramp_tb.sv
